[hw/rtl/bese_pkg.sv]
// shared types, codes and helpers of the boolean expression stream evaluator
package bese_pkg;

    // character codes that act
    localparam logic [7:0] SYM_AND   = 8'h26;
    localparam logic [7:0] SYM_OR    = 8'h7C;
    localparam logic [7:0] SYM_NOT   = 8'h21;
    localparam logic [7:0] SYM_TRUE  = 8'h74;
    localparam logic [7:0] SYM_FALSE = 8'h66;
    localparam logic [7:0] SYM_CLOSE = 8'h29;

    // operator kinds held in a stack entry
    localparam logic [1:0] KIND_AND = 2'd0;
    localparam logic [1:0] KIND_OR  = 2'd1;
    localparam logic [1:0] KIND_NOT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;
    localparam logic [1:0] ST_UNCLOSED  = 2'd3;

    // entries in the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // classified operation
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_DELIVER,
        OP_CLOSE
    } op_t;

    // one classified item
    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       bit_val;
        logic       last;
    } cmd_t;

    // one open operator
    typedef struct packed {
        logic       has_false;
        logic       has_true;
        logic [1:0] kind;
    } entry_t;

    // reduce a closed operator to its truth value
    function automatic logic reduce_entry(input entry_t e);
        logic v;
        unique case (e.kind)
            KIND_AND: v = ~e.has_false;
            KIND_OR:  v = e.has_true;
            default:  v = ~e.has_true;
        endcase
        return v;
    endfunction

    // record an argument value in an open operator
    function automatic entry_t mark_entry(input entry_t e, input logic v);
        entry_t r;
        r = e;
        if (v)
        begin
            r.has_true = 1'b1;
        end
        else
        begin
            r.has_false = 1'b1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/bese_front.sv]
// front end: takes characters and classifies them into stack commands
module bese_front (
    input  logic                symbol_valid,
    output logic                symbol_ready,
    input  logic [7:0]          symbol,
    input  logic                last_symbol,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output bese_pkg::cmd_t      cmd
);

    // decode the character
    always_comb
    begin
        cmd.op      = bese_pkg::OP_NONE;
        cmd.kind    = bese_pkg::KIND_AND;
        cmd.bit_val = 1'b0;
        cmd.last    = last_symbol;
        unique case (symbol)
            bese_pkg::SYM_AND:
            begin
                cmd.op   = bese_pkg::OP_PUSH;
                cmd.kind = bese_pkg::KIND_AND;
            end
            bese_pkg::SYM_OR:
            begin
                cmd.op   = bese_pkg::OP_PUSH;
                cmd.kind = bese_pkg::KIND_OR;
            end
            bese_pkg::SYM_NOT:
            begin
                cmd.op   = bese_pkg::OP_PUSH;
                cmd.kind = bese_pkg::KIND_NOT;
            end
            bese_pkg::SYM_TRUE:
            begin
                cmd.op      = bese_pkg::OP_DELIVER;
                cmd.bit_val = 1'b1;
            end
            bese_pkg::SYM_FALSE:
            begin
                cmd.op = bese_pkg::OP_DELIVER;
            end
            bese_pkg::SYM_CLOSE:
            begin
                cmd.op = bese_pkg::OP_CLOSE;
            end
            default:
            begin
                cmd.op = bese_pkg::OP_NONE;
            end
        endcase
    end

    // handshake passes straight to the queue
    assign cmd_valid    = symbol_valid;
    assign symbol_ready = cmd_ready;

endmodule

[hw/rtl/bese_queue.sv]
// short command queue between front and back
module bese_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  bese_pkg::cmd_t      wr_cmd,
    output logic                rd_valid,
    input  logic                rd_ready,
    output bese_pkg::cmd_t      rd_cmd
);

    localparam int unsigned PW = (bese_pkg::QUEUE_DEPTH > 1) ? $clog2(bese_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(bese_pkg::QUEUE_DEPTH + 1);

    bese_pkg::cmd_t    slot_reg [bese_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_wr, do_rd;

    // handshakes
    assign wr_ready = (count_reg != CW'(bese_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(bese_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(bese_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[hw/rtl/bese_back.sv]
// back end: operator stack, reduction and result register
module bese_back #(
    parameter int unsigned MAX_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  bese_pkg::cmd_t      cmd,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                value,
    output logic [1:0]          status
);

    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

    // stack below the top entry, top entry and the one under it in registers
    bese_pkg::entry_t  stack_mem [MAX_DEPTH];
    bese_pkg::entry_t  top_reg, top_next;
    bese_pkg::entry_t  below_reg;
    logic [DW-1:0]     depth_reg, depth_next;
    logic              top_value_reg, top_value_next;
    logic [1:0]        error_reg, error_next;
    logic              out_valid_reg;
    logic              value_reg, value_next;
    logic [1:0]        status_reg, status_next;

    logic              take;
    logic              wr_en, load_below_top, load_below_mem;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic              red_v;
    logic [DW-1:0]     dec_depth;

    // a final item waits while the result register is still full and result_ready is low
    assign take      = cmd_valid && cmd_ready;
    assign cmd_ready = !cmd.last || !out_valid_reg || result_ready;

    assign wr_addr   = AW'(depth_reg - 1'b1);
    assign rd_addr   = AW'(depth_reg - DW'(3));
    assign dec_depth = depth_reg - 1'b1;
    assign red_v     = bese_pkg::reduce_entry(top_reg);

    // execute one command
    always_comb
    begin
        top_next       = top_reg;
        depth_next     = depth_reg;
        top_value_next = top_value_reg;
        error_next     = error_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        load_below_top = 1'b0;
        load_below_mem = 1'b0;
        if (take && error_reg == bese_pkg::ST_OK)
        begin
            unique case (cmd.op)
                bese_pkg::OP_PUSH:
                begin
                    if (depth_reg == DW'(MAX_DEPTH))
                    begin
                        error_next = bese_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en          = (depth_reg != '0);
                        load_below_top = 1'b1;
                        top_next       = '{has_false: 1'b0, has_true: 1'b0, kind: cmd.kind};
                        depth_next     = depth_reg + 1'b1;
                    end
                end
                bese_pkg::OP_DELIVER:
                begin
                    if (depth_reg != '0)
                    begin
                        top_next = bese_pkg::mark_entry(top_reg, cmd.bit_val);
                    end
                    else
                    begin
                        top_value_next = cmd.bit_val;
                    end
                end
                bese_pkg::OP_CLOSE:
                begin
                    if (depth_reg == '0)
                    begin
                        error_next = bese_pkg::ST_UNMATCHED;
                    end
                    else
                    begin
                        depth_next     = dec_depth;
                        load_below_mem = 1'b1;
                        if (dec_depth != '0)
                        begin
                            top_next = bese_pkg::mark_entry(below_reg, red_v);
                        end
                        else
                        begin
                            top_value_next = red_v;
                        end
                    end
                end
                default:
                begin
                    top_next = top_reg;
                end
            endcase
        end
        // final character: form the result and clear the expression state
        if (take && cmd.last)
        begin
            if (error_next != bese_pkg::ST_OK)
            begin
                status_next = error_next;
            end
            else if (depth_next != '0)
            begin
                status_next = bese_pkg::ST_UNCLOSED;
            end
            else
            begin
                status_next = bese_pkg::ST_OK;
            end
            value_next     = (status_next == bese_pkg::ST_OK) ? top_value_next : 1'b0;
            depth_next     = '0;
            top_value_next = 1'b0;
            error_next     = bese_pkg::ST_OK;
        end
    end

    // control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            top_value_reg <= 1'b0;
            error_reg     <= bese_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            top_value_reg <= top_value_next;
            error_reg     <= error_next;
            if (take && cmd.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // stack memory with registered read of the entry under the top
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (load_below_top)
        begin
            below_reg <= top_reg;
        end
        else if (load_below_mem)
        begin
            below_reg <= stack_mem[rd_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

endmodule

[hw/rtl/bool_expr_stream_evaluator.sv]
// top level of the boolean expression stream evaluator
//
//   channel   handshake                    payload
//   input     symbol_valid/symbol_ready    symbol[7:0], last_symbol
//   result    result_valid/result_ready    value, status[1:0]
//
// One character per cycle sustained, unless a final character waits on a full
// result register; each character passes the decoder and a two-entry command
// queue, then the stack engine acts on it. The result register loads at the
// edge where the back end takes the final character from the queue.
// A full result register stalls only a final character.
// Reset clears depth, top value, error and all handshake state; the stack memory
// needs no clearing, since only entries below the depth count are used.
module bool_expr_stream_evaluator #(
    parameter int unsigned MAX_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        symbol_valid,
    output logic        symbol_ready,
    input  logic [7:0]  symbol,
    input  logic        last_symbol,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        value,
    output logic [1:0]  status
);

    logic              f_valid, f_ready;
    bese_pkg::cmd_t    f_cmd;
    logic              b_valid, b_ready;
    bese_pkg::cmd_t    b_cmd;

    // classify characters
    bese_front u_front (
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd          (f_cmd)
    );

    // decouple front and back
    bese_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_cmd   (b_cmd)
    );

    // stack engine and result
    bese_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (b_valid),
        .cmd_ready    (b_ready),
        .cmd          (b_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

endmodule
